/* rtl/kfsi_pkg.sv */
// ----------------------------------------------------------------------------
// kfsi_pkg: shared definitions for the keyframe seek index
// Widths, constants, request and register codes, and the structures that
// pass between the front end and the execution back end.
// ----------------------------------------------------------------------------
package kfsi_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 512;

   localparam int TIME_W     = 32;
   localparam int OFS_W      = 48;
   localparam int BYTES_W    = 32;
   localparam int LEN_W      = 24;
   localparam int GAP_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int ECOUNT_W   = 10;
   localparam int TENTH_W    = 29;
   localparam int ADD_W      = 34;
   localparam int HDR_W      = 27;
   localparam int QDEPTH     = 2;
   localparam int QLVL_W     = 2;
   localparam int DIV_CNT_W  = 6;

   localparam logic [OFS_W-1:0]     OFS_MAX      = '1;
   localparam logic [BYTES_W-1:0]   RECIP10      = 32'hCCCC_CCCD;
   localparam int                   RECIP_SHIFT  = 35;
   localparam logic [LEN_W-1:0]     META_DEFAULT = 24'd384;
   localparam logic [HDR_W-1:0]     HDR_BASE     = 27'd17;
   localparam logic [HDR_W-1:0]     TAG_OVH      = 27'd15;
   localparam logic [ADD_W-1:0]     VID_EXTRA    = 34'd35;
   localparam logic [ADD_W-1:0]     AUD_EXTRA    = 34'd19;
   localparam logic [GAP_W-1:0]     GAP_RESET    = 16'd2000;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 6'd47;

   typedef enum logic [1:0] {
      REQ_START  = 2'd0,
      REQ_SAMPLE = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_UNUSED = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_META_LEN = 2'd0,
      CSR_VCFG_LEN = 2'd1,
      CSR_ACFG_LEN = 2'd2,
      CSR_MIN_GAP  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_START,
      OP_SAMPLE,
      OP_LOOKUP,
      OP_NONE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_S_SIZE,
      ST_S_GROW,
      ST_L_BEGIN,
      ST_L_FIRST,
      ST_L_SCAN,
      ST_DIV,
      ST_DIV_FIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type               op;
      logic                 video_flag;
      logic                 is_key;
      logic [BYTES_W-1:0]   payload_bytes;
      logic [TENTH_W-1:0]   tenth;
      logic [TIME_W-1:0]    decode_ms;
      logic [TIME_W-1:0]    seek_ms;
   } item_type;

   typedef struct packed {
      logic [LEN_W-1:0] metadata_len;
      logic [LEN_W-1:0] video_config_len;
      logic [LEN_W-1:0] audio_config_len;
      logic [GAP_W-1:0] min_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic [QLVL_W-1:0] level;
   } front_status_type;

   typedef struct packed {
      logic busy;
      logic count_zero;
   } back_status_type;

endpackage

/* rtl/kfsi_if.sv */
// ----------------------------------------------------------------------------
// kfsi_if: request and response channels of the keyframe seek index
// Valid/ready channels carrying one request or one response transaction.
// ----------------------------------------------------------------------------
interface kfsi_req_if import kfsi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic               video_flag;
   logic               is_key;
   logic [BYTES_W-1:0] payload_bytes;
   logic [TIME_W-1:0]  decode_ms;
   logic [TIME_W-1:0]  seek_ms;

   modport source (output valid, req_type, video_flag, is_key, payload_bytes, decode_ms,
                   seek_ms, input ready);
   modport sink (input valid, req_type, video_flag, is_key, payload_bytes, decode_ms,
                 seek_ms, output ready);
endinterface

interface kfsi_rsp_if import kfsi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFS_W-1:0]    position;
   logic [ECOUNT_W-1:0] entry_count;
   logic [OFS_W-1:0]    file_size;
   logic                stored;

   modport source (output valid, position, entry_count, file_size, stored, input ready);
   modport sink (input valid, position, entry_count, file_size, stored, output ready);
endinterface

/* rtl/kfsi_front.sv */
// ----------------------------------------------------------------------------
// kfsi_front: request intake and classification
// Decodes each request, precomputes a tenth of the sample size and queues
// the transaction for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module kfsi_front import kfsi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   kfsi_req_if.sink         req,
   input  logic             pop,
   output logic             head_valid,
   output item_type         head,
   output front_status_type status
);

   item_type          q_ff [QDEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;
   logic              push;
   item_type          item;
   logic [2*BYTES_W-1:0] prod;

   assign req.ready = (level_ff != QLVL_W'(QDEPTH));
   assign push      = req.valid && req.ready;

   // Division by ten through the reciprocal; exact for any 32-bit size.
   always_comb begin
      prod = req.payload_bytes * RECIP10;
      item.video_flag    = req.video_flag;
      item.is_key        = req.is_key;
      item.payload_bytes = req.payload_bytes;
      item.tenth         = prod[RECIP_SHIFT +: TENTH_W];
      item.decode_ms     = req.decode_ms;
      item.seek_ms       = req.seek_ms;
      case (req_code_type'(req.req_type))
         REQ_START:  item.op = OP_START;
         REQ_SAMPLE: item.op = OP_SAMPLE;
         REQ_LOOKUP: item.op = OP_LOOKUP;
         default:    item.op = OP_NONE;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + QLVL_W'(push) - QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head_valid   = (level_ff != '0);
   assign head         = q_ff[rd_ptr_ff];
   assign status.level = level_ff;

endmodule

/* rtl/kfsi_back.sv */
// ----------------------------------------------------------------------------
// kfsi_back: table update, lookup scan and interpolation
// Owns the seek table memories, the running offset and the response
// register; lookups scan the table and divide one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kfsi_back import kfsi_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            head_valid,
   input  item_type        head,
   output logic            pop,
   kfsi_rsp_if.source      rsp,
   output back_status_type status
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = $clog2(MAX_ENTRIES);

   logic [TIME_W-1:0] time_mem [MAX_ENTRIES];
   logic [OFS_W-1:0]  ofs_mem  [MAX_ENTRIES];

   state_type           state_ff, state_in;
   item_type            cur_ff, cur_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [OFS_W-1:0]    running_ff, running_in;
   logic signed [TIME_W:0] last_key_ff, last_key_in;
   logic [TIME_W-1:0]   newest_ff, newest_in;
   logic [ADD_W-1:0]    add_ff, add_in;
   logic [OFS_W-1:0]    res_pos_ff, res_pos_in;
   logic                res_st_ff, res_st_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [TIME_W-1:0]   prev_time_ff, prev_time_in;
   logic [OFS_W-1:0]    prev_ofs_ff, prev_ofs_in;
   logic [TIME_W-1:0]   rd_time_ff;
   logic [OFS_W-1:0]    rd_ofs_ff;
   logic [OFS_W-1:0]    d_ff, d_in;
   logic [TIME_W-1:0]   n_ff, n_in;
   logic [TIME_W-1:0]   m_ff, m_in;
   logic [TIME_W-1:0]   r_ff, r_in;
   logic [OFS_W-1:0]    q_ff, q_in;
   logic                neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] bit_ff, bit_in;
   logic                out_valid_ff, out_valid_in;
   logic [OFS_W-1:0]    out_pos_ff, out_pos_in;
   logic [ECOUNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [OFS_W-1:0]    out_size_ff, out_size_in;
   logic                out_st_ff, out_st_in;

   logic              we;
   logic [AW-1:0]     wa;
   logic [TIME_W-1:0] wt;
   logic [OFS_W-1:0]  wo;
   logic [AW-1:0]     ra;

   always_comb begin
      logic [HDR_W-1:0]  hdr;
      logic [LEN_W-1:0]  meta;
      logic signed [TIME_W+1:0] diff;
      logic              ok;
      logic [OFS_W:0]    sum;
      logic [CW-1:0]     idx_nx;
      logic [TIME_W+1:0] s;
      logic [TIME_W+1:0] m2;
      logic [1:0]        dig;

      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      running_in   = running_ff;
      last_key_in  = last_key_ff;
      newest_in    = newest_ff;
      add_in       = add_ff;
      res_pos_in   = res_pos_ff;
      res_st_in    = res_st_ff;
      idx_in       = idx_ff;
      prev_time_in = prev_time_ff;
      prev_ofs_in  = prev_ofs_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      neg_in       = neg_ff;
      bit_in       = bit_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_pos_in   = out_pos_ff;
      out_cnt_in   = out_cnt_ff;
      out_size_in  = out_size_ff;
      out_st_in    = out_st_ff;
      pop = 1'b0;
      we  = 1'b0;
      wa  = count_ff[AW-1:0];
      wt  = '0;
      wo  = '0;
      ra  = '0;

      meta   = (cfg.metadata_len != '0) ? cfg.metadata_len : META_DEFAULT;
      hdr    = HDR_BASE + HDR_W'(meta) + TAG_OVH
             + ((cfg.video_config_len != '0) ? HDR_W'(cfg.video_config_len) + TAG_OVH : '0)
             + ((cfg.audio_config_len != '0) ? HDR_W'(cfg.audio_config_len) + TAG_OVH : '0);
      diff   = $signed({2'b00, cur_ff.decode_ms}) - $signed({last_key_ff[TIME_W], last_key_ff});
      ok     = (count_ff < CW'(MAX_ENTRIES))
             && ((count_ff == '0) || (diff >= $signed({18'd0, cfg.min_gap_ms})));
      sum    = {1'b0, running_ff} + (OFS_W+1)'(add_ff);
      idx_nx = idx_ff + 1'b1;
      s      = {1'b0, r_ff, 1'b0} + (d_ff[OFS_W-1] ? {2'b00, n_ff} : '0);
      m2     = {1'b0, m_ff, 1'b0};
      dig    = 2'd0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop        = 1'b1;
               cur_in     = head;
               res_pos_in = '0;
               res_st_in  = 1'b0;
               case (head.op)
                  OP_START:  state_in = ST_START;
                  OP_SAMPLE: state_in = ST_S_SIZE;
                  OP_LOOKUP: state_in = ST_L_BEGIN;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_START: begin
            running_in  = OFS_W'(hdr);
            we          = 1'b1;
            wa          = '0;
            wt          = '0;
            wo          = OFS_W'(hdr);
            count_in    = CW'(1);
            last_key_in = (TIME_W+1)'(0) - {17'd0, cfg.min_gap_ms};
            newest_in   = '0;
            res_st_in   = 1'b1;
            state_in    = ST_RESP;
         end
         ST_S_SIZE: begin
            add_in = cur_ff.video_flag
                   ? ADD_W'(cur_ff.payload_bytes) + ADD_W'(cur_ff.tenth) + VID_EXTRA
                   : ADD_W'(cur_ff.payload_bytes) + AUD_EXTRA;
            if (cur_ff.video_flag && cur_ff.is_key) begin
               if (ok) begin
                  we          = 1'b1;
                  wt          = cur_ff.decode_ms;
                  wo          = running_ff;
                  count_in    = count_ff + 1'b1;
                  newest_in   = cur_ff.decode_ms;
                  last_key_in = {1'b0, cur_ff.decode_ms};
                  res_st_in   = 1'b1;
               end else if (count_ff != '0) begin
                  last_key_in = {1'b0, newest_ff};
               end
            end
            state_in = ST_S_GROW;
         end
         ST_S_GROW: begin
            running_in = sum[OFS_W] ? OFS_MAX : sum[OFS_W-1:0];
            state_in   = ST_RESP;
         end
         ST_L_BEGIN: begin
            if (count_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               ra       = '0;
               state_in = ST_L_FIRST;
            end
         end
         ST_L_FIRST: begin
            if (cur_ff.seek_ms <= rd_time_ff) begin
               res_pos_in = rd_ofs_ff;
               state_in   = ST_RESP;
            end else begin
               prev_time_in = rd_time_ff;
               prev_ofs_in  = rd_ofs_ff;
               idx_in       = CW'(1);
               if (CW'(1) < count_ff) begin
                  ra       = AW'(1);
                  state_in = ST_L_SCAN;
               end else begin
                  res_pos_in = rd_ofs_ff;
                  state_in   = ST_RESP;
               end
            end
         end
         ST_L_SCAN: begin
            if (rd_time_ff > cur_ff.seek_ms) begin
               if ((rd_time_ff <= prev_time_ff) || (cur_ff.seek_ms < prev_time_ff)) begin
                  res_pos_in = prev_ofs_ff;
                  state_in   = ST_RESP;
               end else begin
                  neg_in   = (rd_ofs_ff < prev_ofs_ff);
                  d_in     = (rd_ofs_ff < prev_ofs_ff) ? prev_ofs_ff - rd_ofs_ff
                                                       : rd_ofs_ff - prev_ofs_ff;
                  n_in     = cur_ff.seek_ms - prev_time_ff;
                  m_in     = rd_time_ff - prev_time_ff;
                  r_in     = '0;
                  q_in     = '0;
                  bit_in   = DIV_LAST_BIT;
                  state_in = ST_DIV;
               end
            end else begin
               prev_time_in = rd_time_ff;
               prev_ofs_in  = rd_ofs_ff;
               idx_in       = idx_nx;
               if (idx_nx < count_ff) begin
                  ra = idx_nx[AW-1:0];
               end else begin
                  res_pos_in = rd_ofs_ff;
                  state_in   = ST_RESP;
               end
            end
         end
         ST_DIV: begin
            // The remainder stays below the divisor and n is below it too,
            // so each step yields a quotient digit of at most two.
            if (s >= m2) begin
               s   = s - m2;
               dig = 2'd2;
            end else if (s >= {2'b00, m_ff}) begin
               s   = s - {2'b00, m_ff};
               dig = 2'd1;
            end
            r_in   = s[TIME_W-1:0];
            q_in   = {q_ff[OFS_W-2:0], 1'b0} + OFS_W'(dig);
            d_in   = {d_ff[OFS_W-2:0], 1'b0};
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_DIV_FIN;
            end
         end
         ST_DIV_FIN: begin
            res_pos_in = neg_ff ? prev_ofs_ff - q_ff - OFS_W'(r_ff != '0)
                                : prev_ofs_ff + q_ff;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_pos_in   = res_pos_ff;
               out_cnt_in   = ECOUNT_W'(count_ff);
               out_size_in  = running_ff;
               out_st_in    = res_st_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         running_ff   <= '0;
         last_key_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         last_key_ff  <= last_key_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      newest_ff    <= newest_in;
      add_ff       <= add_in;
      res_pos_ff   <= res_pos_in;
      res_st_ff    <= res_st_in;
      idx_ff       <= idx_in;
      prev_time_ff <= prev_time_in;
      prev_ofs_ff  <= prev_ofs_in;
      d_ff         <= d_in;
      n_ff         <= n_in;
      m_ff         <= m_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      neg_ff       <= neg_in;
      bit_ff       <= bit_in;
      out_pos_ff   <= out_pos_in;
      out_cnt_ff   <= out_cnt_in;
      out_size_ff  <= out_size_in;
      out_st_ff    <= out_st_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         time_mem[wa] <= wt;
         ofs_mem[wa]  <= wo;
      end
      rd_time_ff <= time_mem[ra];
      rd_ofs_ff  <= ofs_mem[ra];
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.position    = out_pos_ff;
   assign rsp.entry_count = out_cnt_ff;
   assign rsp.file_size   = out_size_ff;
   assign rsp.stored      = out_st_ff;

   assign status.busy       = (state_ff != ST_IDLE);
   assign status.count_zero = (count_ff == '0);

endmodule

/* rtl/keyframe_seek_index.sv */
// ----------------------------------------------------------------------------
// keyframe_seek_index: seek table builder and lookup engine
// Records (time, byte offset) pairs for keyframes while samples stream in
// and answers seek lookups by interpolation between stored entries.
// ----------------------------------------------------------------------------
// Usage. Requests arrive as transactions on req_chan: a start request opens a
// new table at the estimated header size, a sample request advances the
// running offset (and may store a keyframe entry), and a lookup request asks
// for the byte position of a play time. Every request produces exactly one
// response transaction on rsp_chan, in request order. Header lengths and the
// minimum keyframe spacing are written through the csr_ port while idle.
//
// Sequence. A start runs the start state and a sample the size and grow
// states before the response state registers the response. A lookup runs
// the begin and first-entry states, a scan of the table entries (one memory
// read a cycle) and the bit-serial interpolation divider, one quotient
// bit per cycle. Lookups that clamp or hit equal times skip the divider.
//
// A two-entry queue separates intake from execution, so requests keep being
// accepted while the back end works or a response waits, until full. When the
// receiver stalls, the response holds in its register and the back end waits
// after finishing the next request. Reset empties the table, zeroes the
// running offset and restores the register defaults; no clearing pass is run.
// ----------------------------------------------------------------------------
module keyframe_seek_index import kfsi_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   kfsi_req_if.sink              req_chan,
   kfsi_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers. Writes take effect at once; the host must write
   // them only while no transaction is in flight, which the block does not enforce.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_META_LEN: cfg_in.metadata_len     = csr_wdata;
            CSR_VCFG_LEN: cfg_in.video_config_len = csr_wdata;
            CSR_ACFG_LEN: cfg_in.audio_config_len = csr_wdata;
            CSR_MIN_GAP:  cfg_in.min_gap_ms       = csr_wdata[GAP_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.metadata_len     <= '0;
         cfg_ff.video_config_len <= '0;
         cfg_ff.audio_config_len <= '0;
         cfg_ff.min_gap_ms       <= GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies each request and queues it; the back end
   // pops one request at a time and carries it out.
   logic             head_valid;
   item_type         head;
   logic             pop;
   front_status_type front_status;
   back_status_type  back_status;

   kfsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .status     (front_status)
   );

   kfsi_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_chan),
      .status     (back_status)
   );

   // The queue never holds more transactions than it has room for.
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      front_status.level <= QLVL_W'(QDEPTH))
      else $error("request queue overfilled");

   // A response reporting a stored entry implies the table is not empty.
   a_stored_nonempty : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.stored |-> !back_status.count_zero)
      else $error("stored entry reported with an empty table");

   // The back end only takes a request while idle, so a pop is followed by
   // the back end being busy.
   a_pop_busy : assert property (@(posedge clock) disable iff (reset)
      pop |=> back_status.busy)
      else $error("back end idle after taking a request");

endmodule
